>>> src/sem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight) + 1;
  localparam int unsigned SqW       = 21;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_SQRT
  } state_e;

  typedef enum logic [0:0] {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  // controller to datapath
  typedef struct packed {
    logic start;     // latch item, issue line store read
    logic calc;      // update stores, window, gradients
    logic sqrt_init;
    logic sqrt_step;
    logic [2:0] bit_idx;
  } sem_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ignore;    // item causes nothing
    logic emit;      // item causes a result
  } sem_sts_t;

endpackage
`default_nettype wire

>>> src/sem_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pix_if / sem_res_if / sem_cfg_if
// Valid/ready channels of the block.
// ----------------------------------------------------------------------------
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, kind, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, kind, in_red, in_green, in_blue, output ready);
endinterface

interface sem_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_last;
  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

interface sem_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/sem_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer: accept, line read, gradient, eight square root steps, output.
// ----------------------------------------------------------------------------
module sem_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_busy_i,
  input  wire sem_pkg::sem_sts_t sts_i,
  output sem_pkg::sem_cmd_t      cmd_o,
  output logic                   out_load_o
);
  import sem_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    in_ready_o = 1'b0;
    cmd_o.bit_idx = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        if (sts_i.ignore) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.calc = 1'b1;
          state_d    = sts_i.emit ? ST_CALC : ST_IDLE;
        end
      end
      ST_CALC: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d   = 3'd7;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt_q != 3'd0) begin
          cmd_o.sqrt_step = 1'b1;
          cnt_d = cnt_q - 3'd1;
        end else if (!out_busy_i) begin
          cmd_o.sqrt_step = 1'b1;
          out_load_o      = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> src/sem_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sem_dp
// Line stores, 3x3 window, Sobel sums and bitwise square root per channel.
// ----------------------------------------------------------------------------
module sem_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [10:0]       width_i,
  input  wire logic [12:0]       height_i,
  input  wire logic              kind_i,
  input  wire logic [23:0]       pix_i,
  input  wire sem_pkg::sem_cmd_t cmd_i,
  output sem_pkg::sem_sts_t      sts_o,
  output logic [23:0]            mag_o,
  output logic                   last_o
);
  import sem_pkg::*;

  logic [23:0] upper_mem [MaxWidth];
  logic [23:0] middle_mem [MaxWidth];
  logic [23:0] top_q, mid_q;
  logic [23:0] pix_q;
  logic        kind_q;
  logic [23:0] win_q [9];
  logic [ColW-1:0] in_col_q;
  logic [RowW-1:0] in_row_q;
  logic            last_q, last_d;

  logic [10:0] w_c;
  logic [12:0] h_c;
  logic        pix_phase, col0, row_ge1, row_ge2;
  logic [23:0] newv, topv, midv;
  logic [ColW:0] col_nx;

  // clamped sizes
  always_comb begin
    w_c = (width_i < 11'd2) ? 11'd2 :
          (width_i > 11'(MaxWidth)) ? 11'(MaxWidth) : width_i;
    h_c = (height_i < 13'd2) ? 13'd2 :
          (height_i > 13'(MaxHeight)) ? 13'(MaxHeight) : height_i;
  end

  assign pix_phase = (in_row_q < RowW'(h_c));
  assign col0      = (in_col_q == '0);
  assign row_ge1   = (in_row_q >= RowW'(1));
  assign row_ge2   = (in_row_q >= RowW'(2));
  assign newv      = (pix_phase && kind_q == KIND_PIXEL) ? pix_q : '0;
  assign topv      = row_ge2 ? top_q : '0;
  assign midv      = row_ge1 ? mid_q : '0;
  assign col_nx    = {1'b0, in_col_q} + 1'b1;
  assign last_d    = col0 && (in_row_q >= RowW'(h_c) + RowW'(1));

  assign sts_o.ignore = (kind_q == KIND_FLUSH) && pix_phase;
  assign sts_o.emit   = col0 ? row_ge2 : row_ge1;

  // line store reads and item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      top_q  <= upper_mem[in_col_q];
      mid_q  <= middle_mem[in_col_q];
      pix_q  <= pix_i;
      kind_q <= kind_i;
    end
    if (cmd_i.calc && !sts_o.ignore) begin
      upper_mem[in_col_q]  <= midv;
      middle_mem[in_col_q] <= newv;
    end
  end

  // window, position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
      in_col_q <= '0;
      in_row_q <= '0;
      last_q   <= 1'b0;
    end else if (cmd_i.calc) begin
      last_q <= last_d;
      if (last_d) begin
        for (int k = 0; k < 9; k++) win_q[k] <= '0;
        in_col_q <= '0;
        in_row_q <= '0;
      end else begin
        if (col0) begin
          for (int r = 0; r < 3; r++) begin
            win_q[r*3]   <= '0;
            win_q[r*3+1] <= '0;
          end
        end else begin
          for (int r = 0; r < 3; r++) begin
            win_q[r*3]   <= win_q[r*3+1];
            win_q[r*3+1] <= win_q[r*3+2];
          end
        end
        win_q[2] <= topv;
        win_q[5] <= midv;
        win_q[8] <= newv;
        if (col_nx >= (ColW+1)'(w_c)) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RowW'(1);
        end else begin
          in_col_q <= col_nx[ColW-1:0];
        end
      end
    end
  end

  // window after this item's column shift, as the result sees it
  // a row start shifts in a black column
  logic [23:0] wv [9];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      wv[r*3]   = win_q[r*3+1];
      wv[r*3+1] = win_q[r*3+2];
    end
    wv[2] = col0 ? '0 : topv;
    wv[5] = col0 ? '0 : midv;
    wv[8] = col0 ? '0 : newv;
  end

  // per channel: gradient squares and square root iteration
  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic signed [11:0] gx, gy;
    logic [SqW-1:0]     sum_sq;
    logic [7:0]         t;
    logic [16:0]        tt;
    logic [SqW-1:0]     s_q;
    logic [7:0]         n_q;
    always_comb begin
      logic signed [11:0] v [9];
      for (int k = 0; k < 9; k++) v[k] = 12'(wv[k][ch*8 +: 8]);
      gx = (v[2] - v[0]) + 12'(2) * (v[5] - v[3]) + (v[8] - v[6]);
      gy = (v[6] - v[0]) + 12'(2) * (v[7] - v[1]) + (v[8] - v[2]);
      sum_sq = SqW'(22'(gx * gx) + 22'(gy * gy));
    end
    assign t  = n_q | (8'd1 << cmd_i.bit_idx);
    assign tt = 17'(t) * 17'(t - 8'd1);

    always_ff @(posedge clk_i) begin
      if (cmd_i.calc) begin
        s_q <= sum_sq;
      end
      if (cmd_i.sqrt_init) begin
        n_q <= '0;
      end else if (cmd_i.sqrt_step) begin
        if (s_q > SqW'(65280)) n_q <= 8'd255;
        else if (SqW'(tt) < s_q) n_q <= t;
      end
    end

    assign mag_o[ch*8 +: 8] = n_q;
  end

  assign last_o = last_q;
endmodule
`default_nettype wire

>>> src/sobel_edge_magnitude_rgb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel gradient magnitude on RGB pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each result lags its centre pixel by
// frame_width+1 non-ignored items, and frame_width+1 flush ticks after the
// last pixel drain the frame, the final result carrying frame_last. An item
// with no result is accepted with a line store read, then updates the window
// unless it is an ignored flush tick; one with a result goes on to a root
// set-up step and eight steps of the per channel square root unit. The result
// is offered once the output register has captured the magnitudes of the
// last root step. A finished result waits in the output register while the
// next item is worked on; while it is not taken the sequencer holds at the
// last root step of the following result. Line store contents are undefined
// after reset and are never read before being written for a steady frame size.
module sobel_edge_magnitude_rgb (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sem_cfg_if.sink   cfg,
  sem_pix_if.sink   pix,
  sem_res_if.source res
);
  import sem_pkg::*;

  logic [10:0] width_q;
  logic [12:0] height_q;
  sem_cmd_t    cmd;
  sem_sts_t    sts;
  logic        out_load;
  logic [23:0] mag;
  logic        last;
  logic        res_valid_q;
  logic [23:0] res_data_q;
  logic        res_last_q;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 13'd480;
    end else if (cfg.valid) begin
      case (reg_e'(cfg.index))
        REG_WIDTH:  width_q  <= cfg.data[10:0];
        REG_HEIGHT: height_q <= cfg.data;
        default: ;
      endcase
    end
  end

  sem_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (pix.valid),
    .in_ready_o (pix.ready),
    .out_busy_i (res_valid_q && !res.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .out_load_o (out_load)
  );

  sem_dp u_dp (
    .clk_i, .rst_ni,
    .width_i  (width_q),
    .height_i (height_q),
    .kind_i   (pix.kind),
    .pix_i    ({pix.in_red, pix.in_green, pix.in_blue}),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .mag_o    (mag),
    .last_o   (last)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_load) begin
      res_valid_q <= 1'b1;
    end else if (res.valid && res.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // magnitudes as they stand once the final root step has landed
  logic [23:0] mag_fin;
  always_comb begin
    mag_fin = mag;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_last_q <= last;
    end
  end

  // capture after the final root step lands
  logic load_d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) load_d_q <= 1'b0;
    else         load_d_q <= out_load;
  end
  always_ff @(posedge clk_i) begin
    if (load_d_q) res_data_q <= mag_fin;
  end

  assign res.valid      = res_valid_q && !load_d_q;
  assign res.out_red    = res_data_q[23:16];
  assign res.out_green  = res_data_q[15:8];
  assign res.out_blue   = res_data_q[7:0];
  assign res.frame_last = res_last_q;
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming RGB Sobel edge magnitude block.
// Frames of several small sizes, out of range size values among them, are
// streamed through the pixel channel with random idling on both sides. A
// predictor in the bench works out every result, and the monitor compares
// each result transaction, field by field, with the oldest one predicted.
// ----------------------------------------------------------------------------
module tb;
  import sem_pkg::*;

  typedef struct {
    kind_e      kind;
    logic [23:0] rgb;
  } pix_item_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } mag_t;

  logic clk_i;
  logic rst_ni;

  sem_cfg_if cfg_ch ();
  sem_pix_if pix_ch ();
  sem_res_if res_ch ();

  sobel_edge_magnitude_rgb dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_ch),
    .pix    (pix_ch),
    .res    (res_ch)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  pix_item_t pending_pix[$];
  mag_t      expected_mag[$];
  int        errors;
  int        idle_cycles;
  int        gap_max;
  int        hold_long;
  bit        pix_busy;
  bit        pix_taken;
  bit        res_taken;

  // predictor state
  logic [10:0] cfg_width;
  logic [12:0] cfg_height;
  logic [23:0] line_upper [MaxWidth];
  logic [23:0] line_middle[MaxWidth];
  logic [23:0] win[9];
  int unsigned row_in;
  int unsigned col_in;

  function automatic logic [7:0] round_sqrt(int unsigned s);
    int unsigned n;
    int unsigned t;
    n = 0;
    if (s > 65280) return 8'd255;
    for (int b = 7; b >= 0; b--) begin
      t = n | (1 << b);
      if (t * (t - 1) < s) n = t;
    end
    return n[7:0];
  endfunction

  function automatic logic [7:0] grad_mag(int sh);
    int gx;
    int gy;
    int v[9];
    for (int k = 0; k < 9; k++) v[k] = (win[k] >> sh) & 255;
    gx = v[2] - v[0] + 2 * (v[5] - v[3]) + v[8] - v[6];
    gy = v[6] - v[0] + 2 * (v[7] - v[1]) + v[8] - v[2];
    return round_sqrt(gx * gx + gy * gy);
  endfunction

  function automatic void shift_col(logic [23:0] t, logic [23:0] m, logic [23:0] b);
    logic [23:0] cv[3];
    cv[0] = t; cv[1] = m; cv[2] = b;
    for (int r = 0; r < 3; r++) begin
      win[r * 3]     = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
      win[r * 3 + 2] = cv[r];
    end
  endfunction

  // one accepted pixel transaction through the edge predictor
  function automatic void predict_edge(pix_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    logic [23:0] top;
    logic [23:0] mid;
    logic [23:0] newv;
    bit emit;
    bit last;
    mag_t e;
    w = cfg_width < 2 ? 2 : (cfg_width > MaxWidth ? MaxWidth : cfg_width);
    h = cfg_height < 2 ? 2 : (cfg_height > MaxHeight ? MaxHeight : cfg_height);
    r = row_in;
    c = col_in;
    if (it.kind == KIND_FLUSH && r < h) return;
    newv = (r < h && it.kind == KIND_PIXEL) ? it.rgb : 24'd0;
    top  = r >= 2 ? line_upper[c] : 24'd0;
    mid  = r >= 1 ? line_middle[c] : 24'd0;
    line_upper[c]  = mid;
    line_middle[c] = newv;
    if (c == 0) begin
      shift_col(24'd0, 24'd0, 24'd0);
      emit = r >= 2;
    end else begin
      shift_col(top, mid, newv);
      emit = r >= 1;
    end
    last = (c == 0 && r >= h + 1);
    if (emit) begin
      e.red   = grad_mag(16);
      e.green = grad_mag(8);
      e.blue  = grad_mag(0);
      e.last  = last;
      expected_mag.push_back(e);
    end
    if (c == 0) begin
      for (int k = 0; k < 9; k++) win[k] = 24'd0;
      win[2] = top;
      win[5] = mid;
      win[8] = newv;
    end
    col_in = c + 1;
    if (col_in >= w) begin
      col_in = 0;
      row_in = r + 1;
    end
    if (last) begin
      row_in = 0;
      col_in = 0;
      for (int k = 0; k < 9; k++) win[k] = 24'd0;
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // monitor: predict on accepted pixels, check accepted results
  always @(posedge clk_i) begin
    pix_item_t it;
    mag_t e;
    pix_taken = pix_ch.valid && pix_ch.ready;
    res_taken = res_ch.valid && res_ch.ready;
    if (rst_ni) begin
      if (pix_taken) begin
        it.kind = kind_e'(pix_ch.kind);
        it.rgb  = {pix_ch.in_red, pix_ch.in_green, pix_ch.in_blue};
        predict_edge(it);
      end
      if (res_taken) begin
        if (expected_mag.size() == 0) begin
          report("unexpected result transaction", 1, 0);
        end else begin
          e = expected_mag.pop_front();
          if (res_ch.out_red !== e.red) report("red", res_ch.out_red, e.red);
          if (res_ch.out_green !== e.green) report("green", res_ch.out_green, e.green);
          if (res_ch.out_blue !== e.blue) report("blue", res_ch.out_blue, e.blue);
          if (res_ch.frame_last !== e.last)
            report("frame_last", res_ch.frame_last, e.last);
        end
      end
      // watchdog
      if (pix_taken || res_taken || (cfg_ch.valid && cfg_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 3000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // pixel driver
  always @(negedge clk_i) begin
    int gap;
    pix_item_t it;
    bit nxt_valid;
    if (rst_ni) begin
      if (pix_busy && pix_taken) pix_busy = 1'b0;
      nxt_valid = pix_busy;
      if (!pix_busy) begin
        if (gap > 0) gap--;
        else if (pending_pix.size() > 0) begin
          it = pending_pix.pop_front();
          pix_ch.kind     <= it.kind;
          pix_ch.in_red   <= it.rgb[23:16];
          pix_ch.in_green <= it.rgb[15:8];
          pix_ch.in_blue  <= it.rgb[7:0];
          pix_busy  = 1'b1;
          nxt_valid = 1'b1;
          gap = gap_max == 0 ? 0 : $urandom_range(0, gap_max);
        end
      end
      pix_ch.valid <= nxt_valid;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    int stall;
    if (rst_ni) begin
      if (res_taken) stall = gap_max == 0 ? 0 : $urandom_range(0, gap_max);
      if (hold_long > 0) begin
        hold_long--;
        res_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_e idx, logic [12:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == REG_WIDTH) cfg_width = value[10:0];
    else cfg_height = value;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_item(kind_e k, logic [23:0] rgb);
    pix_item_t it;
    it.kind = k;
    it.rgb  = rgb;
    pending_pix.push_back(it);
  endtask

  // one frame of random content, with ignored flush ticks and drain pixels
  task automatic queue_frame(int w, int h, bit noisy);
    for (int p = 0; p < w * h; p++) begin
      if (noisy && $urandom_range(0, 15) == 0) push_item(KIND_FLUSH, 24'($urandom));
      push_item(KIND_PIXEL, 24'($urandom));
    end
    for (int f = 0; f <= w; f++) begin
      if (noisy && $urandom_range(0, 7) == 0) push_item(KIND_PIXEL, 24'($urandom));
      else push_item(KIND_FLUSH, 24'($urandom));
    end
  endtask

  // wait until the block has taken everything and produced every result
  task automatic drain_all();
    while (pending_pix.size() > 0 || pix_busy || expected_mag.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    int w;
    int h;
    int sent;
    errors = 0;
    idle_cycles = 0;
    gap_max = 11;
    hold_long = 0;
    pix_busy = 1'b0;
    pix_taken = 1'b0;
    res_taken = 1'b0;
    cfg_width = 11'd640;
    cfg_height = 13'd480;
    row_in = 0;
    col_in = 0;
    for (int k = 0; k < 9; k++) win[k] = 24'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = 1'b0;
    cfg_ch.data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.kind = 1'b0;
    pix_ch.in_red = '0;
    pix_ch.in_green = '0;
    pix_ch.in_blue = '0;
    res_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: 3x3 checkerboard of black and white, ignored flush, drain pixel
    write_reg(REG_WIDTH, 13'd3);
    write_reg(REG_HEIGHT, 13'd3);
    for (int p = 0; p < 9; p++) begin
      if (p == 4) push_item(KIND_FLUSH, 24'hFFFFFF);
      push_item(KIND_PIXEL, p[0] ? 24'hFFFFFF : 24'h000000);
    end
    push_item(KIND_FLUSH, 24'd0);
    push_item(KIND_PIXEL, 24'hA5C3F0);
    push_item(KIND_FLUSH, 24'd0);
    push_item(KIND_FLUSH, 24'd0);
    drain_all();

    // smallest frame, out of range values clamp; receiver holds off long
    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, 13'd0);
    hold_long = 400;
    queue_frame(2, 2, 1'b1);
    queue_frame(2, 2, 1'b1);
    drain_all();

    // random frames of small sizes
    sent = 0;
    write_reg(REG_WIDTH, 13'd0);
    write_reg(REG_HEIGHT, 13'd2);
    w = 2;
    h = 2;
    while (sent < 660) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_all();
        gap_max = $urandom_range(0, 3) == 0 ? 0 : 11;
        w = $urandom_range(2, 9);
        h = $urandom_range(2, 6);
        write_reg(REG_WIDTH, 13'(w) | (13'($urandom_range(0, 3)) << 11));
        write_reg(REG_HEIGHT, 13'(h));
      end
      if ($urandom_range(0, 3) == 0) push_item(KIND_FLUSH, 24'($urandom));
      queue_frame(w, h, 1'b1);
      sent += w * h + w + 1;
    end
    drain_all();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/sem_pkg.sv
src/sem_if.sv
src/sem_ctrl.sv
src/sem_dp.sv
src/sobel_edge_magnitude_rgb.sv
tb/sv/tb.sv
